@@ rtl/core/ptc_pkg.sv @@
package ptc_pkg;

   localparam int ROWS    = 128;
   localparam int COLS    = 256;
   localparam int CELLS   = ROWS * COLS;
   localparam int CELL_AW = $clog2(CELLS);

   localparam int PAL_N  = 16;
   localparam int DIST_W = 18;

   localparam logic OP_CONVERT = 1'b0;
   localparam logic OP_CLEAR   = 1'b1;

   typedef logic [3:0]        color_index_type;
   typedef logic [DIST_W-1:0] dist_type;

   typedef struct packed {
      logic       op;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [6:0] cell_row;
      logic [7:0] cell_col;
   } req_type;

   typedef struct packed {
      logic [7:0] char_code;
      logic       char_changed;
      logic [7:0] color_attr;
      logic       color_changed;
   } rsp_type;

   typedef struct packed {
      logic [7:0] char_code;
      logic [7:0] color_attr;
   } cache_entry_type;

   localparam logic [7:0] RAMP [8] = '{
      8'h20, 8'h2E, 8'h2E, 8'h3A, 8'h22, 8'h2A, 8'h23, 8'h25
   };

   localparam logic [7:0] PAL_RED [PAL_N] = '{
      8'd0,   8'd0,   8'd0,   8'd173, 8'd255, 8'd128, 8'd255, 8'd211,
      8'd128, 8'd135, 8'd50,  8'd0,   8'd255, 8'd255, 8'd210, 8'd255
   };
   localparam logic [7:0] PAL_GREEN [PAL_N] = '{
      8'd0,   8'd0,   8'd255, 8'd216, 8'd0,   8'd0,   8'd255, 8'd211,
      8'd128, 8'd206, 8'd205, 8'd255, 8'd192, 8'd0,   8'd180, 8'd255
   };
   localparam logic [7:0] PAL_BLUE [PAL_N] = '{
      8'd0,   8'd255, 8'd0,   8'd230, 8'd0,   8'd128, 8'd0,   8'd211,
      8'd128, 8'd235, 8'd50,  8'd255, 8'd203, 8'd255, 8'd140, 8'd255
   };

   // floor(sum * 7 / 765) as a count of crossed thresholds
   function automatic logic [2:0] ramp_index(input logic [9:0] sum);
      logic [12:0] s7;
      logic [2:0]  idx;
      s7  = 13'(sum) * 13'd7;
      idx = 3'd0;
      for (int k = 1; k < 8; k++) begin
         if (s7 >= 13'(765 * k)) begin
            idx = idx + 3'd1;
         end
      end
      return idx;
   endfunction

endpackage

@@ rtl/core/ptc_palette_match.sv @@
module ptc_palette_match (
   input  logic                     clock,
   input  logic                     advance,
   input  logic [7:0]               red,
   input  logic [7:0]               green,
   input  logic [7:0]               blue,
   output ptc_pkg::color_index_type color_index
);
   import ptc_pkg::*;

   function automatic logic [15:0] sq_diff(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] d;
      d = (a > b) ? (a - b) : (b - a);
      return {8'd0, d} * {8'd0, d};
   endfunction

   dist_type        dist_in [PAL_N];
   dist_type        dist_ff [PAL_N];

   color_index_type pair_a [4];
   color_index_type pair_b [4];
   color_index_type grp_idx_in [4];
   color_index_type grp_idx_ff [4];
   dist_type        grp_dist_in [4];
   dist_type        grp_dist_ff [4];

   logic [1:0]      fin_a;
   logic [1:0]      fin_b;
   logic [1:0]      fin_w;

   always_comb begin
      for (int k = 0; k < PAL_N; k++) begin
         dist_in[k] = DIST_W'(sq_diff(PAL_RED[k], red))
                    + DIST_W'(sq_diff(PAL_GREEN[k], green))
                    + DIST_W'(sq_diff(PAL_BLUE[k], blue));
      end
   end

   // 16 -> 4, ties keep the lower index
   always_comb begin
      for (int g = 0; g < 4; g++) begin
         pair_a[g] = color_index_type'(4 * g);
         if (dist_ff[4 * g + 1] < dist_ff[4 * g]) begin
            pair_a[g] = color_index_type'(4 * g + 1);
         end
         pair_b[g] = color_index_type'(4 * g + 2);
         if (dist_ff[4 * g + 3] < dist_ff[4 * g + 2]) begin
            pair_b[g] = color_index_type'(4 * g + 3);
         end
         grp_idx_in[g] = pair_a[g];
         if (dist_ff[pair_b[g]] < dist_ff[pair_a[g]]) begin
            grp_idx_in[g] = pair_b[g];
         end
         grp_dist_in[g] = dist_ff[grp_idx_in[g]];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         dist_ff     <= dist_in;
         grp_idx_ff  <= grp_idx_in;
         grp_dist_ff <= grp_dist_in;
      end
   end

   // 4 -> 1
   always_comb begin
      fin_a = 2'd0;
      if (grp_dist_ff[1] < grp_dist_ff[0]) begin
         fin_a = 2'd1;
      end
      fin_b = 2'd2;
      if (grp_dist_ff[3] < grp_dist_ff[2]) begin
         fin_b = 2'd3;
      end
      fin_w = fin_a;
      if (grp_dist_ff[fin_b] < grp_dist_ff[fin_a]) begin
         fin_w = fin_b;
      end
      color_index = grp_idx_ff[fin_w];
   end

endmodule

@@ rtl/core/pixel_to_text_cell_converter.sv @@
// Pixel to text-cell converter. One pixel transfer is taken per clock while req_stall is low;
// its result reaches the rsp register through three pipeline stages (palette distances, a 16 to 4
// minimum search with the cell cache read, then the final pick, cache compare and write-back).
// The character and attribute of every cell live in one 32768 x 16 single-port-read,
// single-port-write memory; a one-entry bypass covers a write that lands in the same cycle as
// the read of the next pixel. After reset req_stall stays high while the memory is swept to zero;
// after every clear transfer it stays high while the pipeline drains and then during that sweep; a
// clear produces no response. A stall on a valid rsp holds the whole pipeline.
module pixel_to_text_cell_converter_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ptc_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ptc_pkg::rsp_type rsp_data
);
   import ptc_pkg::*;

   localparam logic [1:0] ST_RUN   = 2'd0;
   localparam logic [1:0] ST_DRAIN = 2'd1;
   localparam logic [1:0] ST_SWEEP = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic [CELL_AW-1:0]  sweep_ff, sweep_in;
   logic                sweeping;
   logic                advance;
   logic                accept;

   logic                s1_valid_ff;
   req_type             s1_ff;
   logic [7:0]          s1_char;
   logic                s1_in_range;
   logic [CELL_AW-1:0]  s1_addr;

   logic                s2_valid_ff;
   logic [7:0]          s2_char_ff;
   logic                s2_in_range_ff;
   logic [CELL_AW-1:0]  s2_addr_ff;

   logic                s3_valid_ff;
   logic [7:0]          s3_char_ff;
   logic                s3_in_range_ff;
   logic [CELL_AW-1:0]  s3_addr_ff;
   color_index_type     s3_color;
   cache_entry_type     s3_entry;
   cache_entry_type     s3_cached;
   logic                s3_fwd_hit;

   cache_entry_type     cache_mem [CELLS];
   cache_entry_type     rd_data_ff;
   logic                mem_re;
   logic                mem_we;
   logic [CELL_AW-1:0]  mem_waddr;
   cache_entry_type     mem_wdata;

   logic                fwd_valid_ff;
   logic [CELL_AW-1:0]  fwd_addr_ff;
   cache_entry_type     fwd_data_ff;

   logic                rsp_valid_ff;
   rsp_type             rsp_ff;
   rsp_type             rsp_in;

   assign sweeping  = (state_ff == ST_SWEEP);
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_RUN) || !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      sweep_in = sweep_ff;
      case (state_ff)
         ST_RUN: begin
            if (accept && req_data.op == OP_CLEAR) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!s1_valid_ff && !s2_valid_ff && !s3_valid_ff) begin
               state_in = ST_SWEEP;
               sweep_in = '0;
            end
         end
         ST_SWEEP: begin
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == CELL_AW'(CELLS - 1)) begin
               state_in = ST_RUN;
            end
         end
         default: begin
            state_in = ST_SWEEP;
            sweep_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_SWEEP;
         sweep_ff <= '0;
      end else begin
         state_ff <= state_in;
         sweep_ff <= sweep_in;
      end
   end

   // stage 1
   always_comb begin
      s1_char     = RAMP[ramp_index(10'(s1_ff.red) + 10'(s1_ff.green) + 10'(s1_ff.blue))];
      s1_in_range = (32'(s1_ff.cell_row) < ROWS) && (32'(s1_ff.cell_col) < COLS);
      s1_addr     = CELL_AW'(32'(s1_ff.cell_row) * COLS + 32'(s1_ff.cell_col));
   end

   ptc_palette_match u_match (
      .clock       (clock),
      .advance     (advance),
      .red         (s1_ff.red),
      .green       (s1_ff.green),
      .blue        (s1_ff.blue),
      .color_index (s3_color)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= accept && req_data.op == OP_CONVERT;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_ff          <= req_data;
         s2_char_ff     <= s1_char;
         s2_in_range_ff <= s1_in_range;
         s2_addr_ff     <= s1_addr;
         s3_char_ff     <= s2_char_ff;
         s3_in_range_ff <= s2_in_range_ff;
         s3_addr_ff     <= s2_addr_ff;
      end
   end

   // cell cache
   assign mem_re    = advance && s2_valid_ff && s2_in_range_ff;
   assign mem_we    = sweeping || (advance && s3_valid_ff && s3_in_range_ff);
   assign mem_waddr = sweeping ? sweep_ff : s3_addr_ff;
   assign mem_wdata = sweeping ? cache_entry_type'('0) : s3_entry;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         cache_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= cache_mem[s2_addr_ff];
      end
   end

   // write that coincided with this item's read
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_valid_ff <= 1'b0;
      end else if (sweeping) begin
         fwd_valid_ff <= 1'b0;
      end else if (advance) begin
         fwd_valid_ff <= s3_valid_ff && s3_in_range_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         fwd_addr_ff <= s3_addr_ff;
         fwd_data_ff <= s3_entry;
      end
   end

   // stage 3
   always_comb begin
      s3_entry.char_code  = s3_char_ff;
      s3_entry.color_attr = {s3_color, 4'hF};
      s3_fwd_hit          = fwd_valid_ff && (fwd_addr_ff == s3_addr_ff);
      s3_cached           = s3_fwd_hit ? fwd_data_ff : rd_data_ff;
      rsp_in.char_code     = s3_entry.char_code;
      rsp_in.color_attr    = s3_entry.color_attr;
      rsp_in.char_changed  = !s3_in_range_ff || (s3_cached.char_code != s3_entry.char_code);
      rsp_in.color_changed = !s3_in_range_ff || (s3_cached.color_attr != s3_entry.color_attr);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ rtl/core/ptc_checker.sv @@
module ptc_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input ptc_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input ptc_pkg::rsp_type rsp_data
);
   import ptc_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   a_attr_low: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.color_attr[3:0] == 4'hF)
      else $error("attribute low nibble not set");

   a_char_ramp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.char_code == RAMP[0] || rsp_data.char_code == RAMP[1]
                  || rsp_data.char_code == RAMP[3] || rsp_data.char_code == RAMP[4]
                  || rsp_data.char_code == RAMP[5] || rsp_data.char_code == RAMP[6]
                  || rsp_data.char_code == RAMP[7]))
      else $error("character outside ramp");

   a_reset_sweep: assert property (@(posedge clock)
      reset |=> req_stall)
      else $error("request taken during post-reset sweep");

   a_clear_stall: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.op == OP_CLEAR |=> req_stall)
      else $error("request taken right after clear");

endmodule

bind pixel_to_text_cell_converter_unit ptc_checker u_checker (.*);
